// ----- rtl/round_robin_tick_scheduler_assert.svh -----
// Assertion macros for the scheduler's control module.
// Each macro takes a label, an antecedent, a consequent and a message.
// The modules that use them provide aclk and aresetn.
`ifndef ROUND_ROBIN_TICK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_ASSERT_SVH

`define RRTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rrts_pkg.sv -----
package rrts_pkg;

    localparam int SLOTS_DEF = 16;

    localparam int MODE_W  = 2;
    localparam int FIELD_W = 4;
    localparam int TICKS_W = 16;
    localparam int COUNT_W = 64;

    localparam logic [TICKS_W-1:0] SLICE_RESET = 16'd2;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] current_slot;
        logic               switched;
        logic [FIELD_W-1:0] new_slot;
        logic               error;
    } rrts_result_t;

endpackage

// ----- rtl/rrts_tick_mem.sv -----
module rrts_tick_mem
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [TICKS_W-1:0] wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [TICKS_W-1:0] rd_data
);

    logic [TICKS_W-1:0] ticks_ram [SLOTS];
    logic [SLOTS-1:0]   written_reg;
    logic [TICKS_W-1:0] rd_data_reg;
    logic               rd_written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ticks_ram[wr_addr] <= wr_data;
        end
        rd_data_reg <= ticks_ram[rd_addr];
    end

    // An entry that was never written reads as the reset slice.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            rd_written_reg <= written_reg[rd_addr];
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : SLICE_RESET;

endmodule

// ----- rtl/rrts_ctrl.sv -----
module rrts_ctrl
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [FIELD_W-1:0] in_slot,
    input  logic [TICKS_W-1:0] in_ticks,
    input  logic [TICKS_W-1:0] slice,
    output logic               res_valid,
    input  logic               res_ready,
    output rrts_result_t       res,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [TICKS_W-1:0] wr_data,
    output logic [IDX_W-1:0]   rd_addr,
    input  logic [TICKS_W-1:0] rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_TICK   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_ADD    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   running_reg, running_next;
    logic [IDX_W-1:0]   before_reg, before_next;
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [SLOTS-1:0]   sleep_reg, sleep_next;
    logic [FIELD_W-1:0] new_slot_reg, new_slot_next;
    logic               error_reg, error_next;

    logic [TICKS_W-1:0] dec;
    logic [IDX_W-1:0]   tslot_idx;
    logic               slot_bad;
    logic [IDX_W-1:0]   ptr_wrap;
    logic [IDX_W-1:0]   cur_wrap;

    assign dec       = (rd_data == '0) ? '0 : rd_data - TICKS_W'(1);
    assign tslot_idx = IDX_W'(in_slot);
    assign slot_bad  = (in_slot == '0) || (32'(in_slot) >= SLOTS) || !valid_reg[tslot_idx];
    assign ptr_wrap  = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
    assign cur_wrap  = (running_reg == LAST_IDX) ? '0 : running_reg + IDX_W'(1);

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        running_next  = running_reg;
        before_next   = before_reg;
        valid_next    = valid_reg;
        sleep_next    = sleep_reg;
        new_slot_next = new_slot_reg;
        error_next    = error_reg;
        wr_en         = 1'b0;
        wr_addr       = ptr_reg;
        wr_data       = slice;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    before_next   = running_reg;
                    new_slot_next = '0;
                    error_next    = 1'b0;
                    state_next    = ST_FINISH;
                    case (in_mode)
                        MODE_TICK: begin
                            state_next = ST_TICK;
                        end
                        MODE_SLEEP: begin
                            if (slot_bad) begin
                                error_next = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = tslot_idx;
                                wr_data = (in_ticks == '0) ? slice : in_ticks;
                                sleep_next[tslot_idx] = (in_ticks != '0);
                            end
                        end
                        MODE_ADD: begin
                            ptr_next   = IDX_W'(1);
                            state_next = ST_ADD;
                        end
                        default: begin
                            error_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                wr_en   = 1'b1;
                wr_addr = running_reg;
                wr_data = dec;
                if (sleep_reg[running_reg] && dec == '0) begin
                    sleep_next[running_reg] = 1'b0;
                    wr_data    = slice;
                    state_next = ST_FINISH;
                end else if (!sleep_reg[running_reg] && dec != '0) begin
                    state_next = ST_FINISH;
                end else begin
                    ptr_next   = cur_wrap;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (valid_reg[ptr_reg]) begin
                    wr_en = 1'b1;
                    if (sleep_reg[ptr_reg] && dec != '0) begin
                        wr_data  = dec;
                        ptr_next = ptr_wrap;
                    end else begin
                        sleep_next[ptr_reg] = 1'b0;
                        running_next = ptr_reg;
                        state_next   = ST_FINISH;
                    end
                end else begin
                    ptr_next = ptr_wrap;
                end
            end
            ST_ADD: begin
                if (!valid_reg[ptr_reg]) begin
                    valid_next[ptr_reg] = 1'b1;
                    sleep_next[ptr_reg] = 1'b0;
                    wr_en         = 1'b1;
                    new_slot_next = FIELD_W'(ptr_reg);
                    state_next    = ST_FINISH;
                end else if (ptr_reg == LAST_IDX) begin
                    error_next = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        rd_addr = (state_reg == ST_IDLE) ? running_reg : ptr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            running_reg <= '0;
            valid_reg   <= SLOTS'(1);
            sleep_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            running_reg <= running_next;
            valid_reg   <= valid_next;
            sleep_reg   <= sleep_next;
        end
    end

    always_ff @(posedge aclk) begin
        before_reg   <= before_next;
        new_slot_reg <= new_slot_next;
        error_reg    <= error_next;
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_FINISH);
    assign res.current_slot = FIELD_W'(running_reg);
    assign res.switched     = (running_reg != before_reg);
    assign res.new_slot     = new_slot_reg;
    assign res.error        = error_reg;

`include "round_robin_tick_scheduler_assert.svh"

    `RRTS_ASSERT_SAME(a_idle_valid, 1'b1, valid_reg[0], "Idle slot lost its valid bit.")
    `RRTS_ASSERT_SAME(a_idle_awake, 1'b1, !sleep_reg[0], "Idle slot is marked sleeping.")
    `RRTS_ASSERT_SAME(a_running_valid, 1'b1, valid_reg[running_reg], "Running slot is not valid.")
    `RRTS_ASSERT_SAME(a_ptr_range, state_reg == ST_SCAN || state_reg == ST_ADD,
        32'(ptr_reg) < SLOTS, "Slot pointer is out of range.")
    `RRTS_ASSERT_NEXT(a_finish_leaves, state_reg == ST_FINISH && res_ready,
        state_reg == ST_IDLE, "Result was taken but the sequencer did not return to idle.")

endmodule

// ----- rtl/round_robin_tick_scheduler.sv -----
// Round-robin time-slice thread scheduler.
// The s_ channel carries one request per word: a timer tick, a sleep request
// or an add-thread request, with the request kind in s_tuser. The m_ channel
// returns exactly one result word per request: the running slot, a switch
// flag, the slot given to an added thread, an error flag and the tick count.
// The slice length is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the scheduler is idle, as the block does not enforce it.
// One request is handled at a time. A sleep request or an unused kind goes
// from acceptance straight to the result. A tick passes through the tick
// state and, when a switch is needed, through a scan that visits one slot per
// cycle through the single read port of the tick memory.
// An add request searches one slot per cycle for a free slot.
// The result sits in an output register; a new request is accepted once the
// previous result has been moved there, even while the receiver stalls.
// After reset only slot 0 is valid and running, every count holds the reset
// slice of two ticks, the slice register is two and the tick count is zero.
module round_robin_tick_scheduler
    import rrts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // slice_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // thread_slot, sleep_ticks
    input  logic [1:0]  s_tuser,       // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata        // current_slot, switched, new_slot, error, tick_count
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [TICKS_W-1:0] slice_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               m_tvalid_reg;
    logic [79:0]        m_tdata_reg;

    logic               in_ready;
    logic               res_valid;
    logic               res_ready;
    rrts_result_t       res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [TICKS_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [TICKS_W-1:0] rd_data;

    rrts_tick_mem #(
        .SLOTS(SLOTS)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    rrts_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .in_mode  (s_tuser),
        .in_slot  (s_tdata[3:0]),
        .in_ticks (s_tdata[19:4]),
        .slice    (slice_reg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    assign s_tready  = in_ready;
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reg    <= SLICE_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slice_reg <= cfg_wr_data;
            end
            if (s_tvalid && in_ready && s_tuser == MODE_TICK) begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (res_valid && res_ready) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {6'd0, count_reg, res.error, res.new_slot,
                            res.switched, res.current_slot};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
